>>> hw/rtl/vgrm_pkg.sv
// vgrm_pkg: shared types and constants of the voxel grid ray marcher.
// Used by vgrm_div, vgrm_lane and voxel_grid_ray_march under hw/rtl; depends on nothing.
package vgrm_pkg;

    // request function codes
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_FILL  = 2'd2,
        FN_RAY   = 2'd3
    } t_func;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd4;

    // register reset values
    localparam logic [5:0]  SIZE_RESET = 6'd32;
    localparam logic [30:0] EDGE_RESET = 31'd65536;
    localparam logic [8:0]  MASK_RESET = 9'd28;

    // squared length below this (about 0.0001 in Q16.16) gives no hit
    localparam logic [63:0] MIN_LEN_SQ = 64'd43;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SQ,
        ST_SQRT,
        ST_DIVN,
        ST_MULI,
        ST_DIVS,
        ST_DIVO,
        ST_MARCH
    } t_state;

    // divider request; short_op divides a 32-bit dividend
    typedef struct packed {
        logic        start;
        logic        short_op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    // march lane control
    typedef struct packed {
        logic load;
        logic adv_a;
        logic adv_b;
    } t_lane_ctl;

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

>>> hw/rtl/vgrm_ram.sv
// vgrm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgrm_ram #(
    parameter int WIDTH  = 4,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/vgrm_div.sv
// vgrm_div: shared restoring divider, one quotient bit per cycle.
// Depends on vgrm_pkg (t_div_req).
module vgrm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vgrm_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic [63:0]         o_quot,
    output logic [31:0]         o_rem
);
    import vgrm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [63:0] r_quot;

    logic [32:0] cand;
    logic        ge;
    logic [32:0] diff;

    // trial subtract of the divisor
    always_comb begin
        cand = {r_rem, r_num[63]};
        ge   = (cand >= {1'b0, r_dvs});
        diff = cand - {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 7'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.short_op ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.short_op ? {i_req.dividend[31:0], 32'd0} : i_req.dividend;
            r_rem  <= '0;
            r_quot <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= ge ? diff[31:0] : cand[31:0];
            r_quot <= {r_quot[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

>>> hw/rtl/vgrm_sqrt.sv
// vgrm_sqrt: integer square root of a 64-bit value, one root bit per cycle.
// No dependencies.
module vgrm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] diff;

    // bring in two bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem, r_num[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[61:0], 2'b00};
            r_rem  <= ge ? diff[33:0] : rem_sh[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> hw/rtl/vgrm_lane.sv
// vgrm_lane: one axis of the march; tracks distance, sample position and tile.
// Depends on vgrm_pkg (t_lane_ctl).
module vgrm_lane #(
    parameter int STEP_W = 11
) (
    input  logic                      i_clk,
    input  vgrm_pkg::t_lane_ctl       i_ctl,
    input  logic [61:0]               i_inc,
    input  logic                      i_neg,
    input  logic signed [31:0]        i_org,
    input  logic signed [STEP_W+33:0] i_t0,
    input  logic [30:0]               i_rem0,
    input  logic [30:0]               i_edge,
    output logic signed [STEP_W+32:0] o_p,
    output logic signed [STEP_W+33:0] o_t
);
    import vgrm_pkg::*;

    localparam int ACC_W = 62 + STEP_W;
    localparam int OFF_W = ACC_W - 31;
    localparam int P_W   = OFF_W + 2;
    localparam int T_W   = STEP_W + 34;

    logic [ACC_W-1:0]     r_acc;
    logic [OFF_W-1:0]     r_off;
    logic [OFF_W-1:0]     r_off_prev;
    logic [30:0]          r_rem;
    logic signed [T_W-1:0] r_t;
    logic signed [P_W-1:0] r_p;

    logic [31:0]           delta;
    logic [32:0]           sum_up;
    logic [32:0]           sum_dn;
    logic [32:0]           up_wrap;
    logic [32:0]           dn_wrap;
    logic signed [P_W-1:0] org_ext;
    logic signed [P_W-1:0] off_ext;
    logic signed [P_W-1:0] n_p;
    logic [30:0]           n_rem;
    logic signed [T_W-1:0] n_t;

    // position and tile remainder update, at most one tile per step
    always_comb begin
        delta   = 32'(r_off - r_off_prev);
        sum_up  = {2'b00, r_rem} + {1'b0, delta};
        sum_dn  = {2'b00, r_rem} - {1'b0, delta};
        up_wrap = sum_up - {2'b00, i_edge};
        dn_wrap = sum_dn + {2'b00, i_edge};
        org_ext = {{(P_W-32){i_org[31]}}, i_org};
        off_ext = $signed({2'b00, r_off});
        n_p     = i_neg ? (org_ext - off_ext) : (org_ext + off_ext);
        n_rem   = sum_up[30:0];
        n_t     = r_t;
        if (!i_neg) begin
            if (sum_up >= {2'b00, i_edge}) begin
                n_rem = up_wrap[30:0];
                n_t   = r_t + T_W'(1);
            end
        end else begin
            n_rem = sum_dn[30:0];
            if (sum_dn[32]) begin
                n_rem = dn_wrap[30:0];
                n_t   = r_t - T_W'(1);
            end
        end
    end

    // stage A: distance accumulator; stage B: position and tile
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc      <= '0;
            r_off_prev <= '0;
            r_rem      <= i_rem0;
            r_t        <= i_t0;
        end else begin
            if (i_ctl.adv_a) begin
                r_off <= r_acc[ACC_W-1:31];
                r_acc <= r_acc + ACC_W'(i_inc);
            end
            if (i_ctl.adv_b) begin
                r_off_prev <= r_off;
                r_rem      <= n_rem;
                r_t        <= n_t;
                r_p        <= n_p;
            end
        end
    end

    assign o_p = r_p;
    assign o_t = r_t;
endmodule

>>> hw/rtl/voxel_grid_ray_march.sv
// voxel_grid_ray_march: tile store with write, read, fill and fixed-step ray march.
// Depends on vgrm_pkg, vgrm_ram, vgrm_div, vgrm_sqrt and vgrm_lane.
//
// One request at a time: start is taken while busy is low, and each request
// gives exactly one result, shown for a single cycle with o_valid; the receiver
// cannot hold it off. A write gives its result in the cycle after start; a read
// passes through ST_READ before its result is registered. A fill sweeps the
// store one entry per cycle. After reset the same sweep clears the store to
// empty with busy high; configuration writes are taken meanwhile. A raycast
// first sets up through the shared divider (one bit per cycle for the three
// direction components, the step count and the three origin tiles) and the
// bit-serial square root, then marches at most MAX_STEPS steps; the steps run
// through a short pipeline with one store read per cycle.
module voxel_grid_ray_march #(
    parameter int MAX_DIM_X = 32,
    parameter int MAX_DIM_Y = 32,
    parameter int MAX_DIM_Z = 32,
    parameter int MAX_STEPS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_func,
    input  logic signed [15:0]                   i_cell_x,
    input  logic signed [15:0]                   i_cell_y,
    input  logic signed [15:0]                   i_cell_z,
    input  logic [3:0]                           i_tile_code,
    input  logic signed [31:0]                   i_origin_x,
    input  logic signed [31:0]                   i_origin_y,
    input  logic signed [31:0]                   i_origin_z,
    input  logic signed [31:0]                   i_dir_x,
    input  logic signed [31:0]                   i_dir_y,
    input  logic signed [31:0]                   i_dir_z,
    input  logic [30:0]                          i_reach,
    input  logic                                 i_cfg_we,
    input  logic [vgrm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vgrm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    output logic [3:0]                           o_read_code,
    output logic                                 o_hit,
    output logic signed [31:0]                   o_hit_x,
    output logic signed [31:0]                   o_hit_y,
    output logic signed [31:0]                   o_hit_z
);
    import vgrm_pkg::*;

    localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int T_W   = SW + 34;
    localparam int P_W   = SW + 33;

    // ------------------------------------------------------------------
    // helpers
    function automatic logic [8:0] f_clamp(input logic [5:0] g, input int m);
        logic [8:0] ge;
        ge = {3'b000, g};
        return (ge > 9'(m)) ? 9'(m) : ge;
    endfunction

    function automatic logic f_inb(input logic [T_W-1:0] t, input logic [8:0] size);
        return !t[T_W-1] && (t[T_W-2:0] < (T_W-1)'(size));
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] z);
        logic [31:0] lin;
        lin = (32'(z) * 32'(MAX_DIM_Y) + 32'(y)) * 32'(MAX_DIM_X) + 32'(x);
        return lin[AW-1:0];
    endfunction

    function automatic logic [31:0] f_sat(input logic [P_W-1:0] p);
        logic ovf;
        ovf = !((&p[P_W-1:31]) || !(|p[P_W-1:31]));
        if (ovf) begin
            return p[P_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return p[31:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    t_state              r_state, n_state;
    logic [5:0]          r_size_x, r_size_y, r_size_z;
    logic [30:0]         r_edge;
    logic [8:0]          r_mask;
    logic [AW-1:0]       r_clr_addr;
    logic [3:0]          r_fill_code;
    logic                r_clr_report;
    logic [1:0]          r_idx;
    logic                r_sub;
    logic [SW-1:0]       r_k;
    logic [SW-1:0]       r_m;
    logic                r_va, r_vb, r_vc;
    logic                r_la, r_lb, r_lc;
    logic                r_inb_c;
    logic                r_inb_rd;
    logic signed [31:0]  r_org [3];
    logic [31:0]         r_mag [3];
    logic                r_neg [3];
    logic [30:0]         r_reach;
    logic [63:0]         r_sum;
    logic [31:0]         r_len;
    logic [30:0]         r_nmag [3];
    logic [61:0]         r_inc [3];
    logic [T_W-1:0]      r_t0 [3];
    logic [30:0]         r_rem0 [3];
    logic [63:0]         r_prod;
    logic [P_W-1:0]      r_pc [3];
    logic                r_valid;
    logic [3:0]          r_read_code;
    logic                r_hit;
    logic [31:0]         r_hit_p [3];

    // ------------------------------------------------------------------
    // combinational signals
    logic                accept;
    t_func               func;
    logic [8:0]          size_x, size_y, size_z;
    logic [30:0]         edge_eff;
    logic [T_W-1:0]      cx, cy, cz;
    logic                cell_inb;
    logic [AW-1:0]       cell_addr;
    logic                clr_last;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [3:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [3:0]          ram_rdata;
    t_div_req            div_req;
    logic                div_done;
    logic [63:0]         div_quot;
    logic [31:0]         div_rem;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [31:0]         sqrt_root;
    t_lane_ctl           lane_ctl;
    logic [P_W-1:0]      lane_p [3];
    logic [T_W-1:0]      lane_t [3];
    logic                march_inb;
    logic [AW-1:0]       march_addr;
    logic [31:0]         mul_a, mul_b;
    logic                step_a;
    logic [15:0]         mask_ext;
    logic                hit_now;
    logic                short_dir;
    logic                fin_write, fin_read, fin_fill, fin_short, fin_march, fin_any;
    logic [31:0]         org_q;
    logic [T_W-1:0]      t0_val;
    logic [30:0]         rem0_val;
    logic [30:0]         rem_lo;
    logic [63:0]         steps_max;

    // ------------------------------------------------------------------
    // decode, bounds and addresses
    always_comb begin
        accept    = start && (r_state == ST_IDLE);
        func      = t_func'(i_func);
        size_x    = f_clamp(r_size_x, MAX_DIM_X);
        size_y    = f_clamp(r_size_y, MAX_DIM_Y);
        size_z    = f_clamp(r_size_z, MAX_DIM_Z);
        edge_eff  = (r_edge == '0) ? 31'd1 : r_edge;
        cx        = T_W'(i_cell_x);
        cy        = T_W'(i_cell_y);
        cz        = T_W'(i_cell_z);
        cx        = {{(T_W-16){i_cell_x[15]}}, i_cell_x};
        cy        = {{(T_W-16){i_cell_y[15]}}, i_cell_y};
        cz        = {{(T_W-16){i_cell_z[15]}}, i_cell_z};
        cell_inb  = f_inb(cx, size_x) && f_inb(cy, size_y) && f_inb(cz, size_z);
        cell_addr = f_addr(cx[7:0], cy[7:0], cz[7:0]);
        march_inb = f_inb(lane_t[0], size_x) && f_inb(lane_t[1], size_y) &&
                    f_inb(lane_t[2], size_z);
        march_addr = f_addr(lane_t[0][7:0], lane_t[1][7:0], lane_t[2][7:0]);
        clr_last  = (r_clr_addr == AW'(DEPTH - 1));
        mask_ext  = {7'd0, r_mask};
        hit_now   = r_vc && r_inb_c && mask_ext[ram_rdata];
        short_dir = (r_sum < MIN_LEN_SQ);
        steps_max = 64'(MAX_STEPS);
    end

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (func)
                        FN_WRITE: n_state = ST_IDLE;
                        FN_READ:  n_state = ST_READ;
                        FN_FILL:  n_state = ST_CLEAR;
                        FN_RAY:   n_state = ST_SQ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_READ: n_state = ST_IDLE;
            ST_SQ: begin
                if (r_idx == 2'd3) n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (!r_sub && short_dir) n_state = ST_IDLE;
                else if (sqrt_done) n_state = ST_DIVN;
            end
            ST_DIVN: begin
                if (div_done && (r_idx == 2'd2)) n_state = ST_MULI;
            end
            ST_MULI: begin
                if (r_idx == 2'd3) n_state = ST_DIVS;
            end
            ST_DIVS: begin
                if (div_done) n_state = ST_DIVO;
            end
            ST_DIVO: begin
                if (div_done && (r_idx == 2'd2)) n_state = ST_MARCH;
            end
            ST_MARCH: begin
                if (fin_march) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs
    always_comb begin
        // store ports
        ram_we    = (r_state == ST_CLEAR) || (accept && (func == FN_WRITE) && cell_inb);
        ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : cell_addr;
        ram_wdata = (r_state == ST_CLEAR) ? r_fill_code : i_tile_code;
        ram_raddr = (r_state == ST_IDLE) ? cell_addr : march_addr;

        // shared multiplier operands
        mul_a = '0;
        mul_b = '0;
        unique case (r_idx)
            2'd0: begin
                mul_a = (r_state == ST_MULI) ? {1'b0, r_nmag[0]} : r_mag[0];
            end
            2'd1: begin
                mul_a = (r_state == ST_MULI) ? {1'b0, r_nmag[1]} : r_mag[1];
            end
            2'd2: begin
                mul_a = (r_state == ST_MULI) ? {1'b0, r_nmag[2]} : r_mag[2];
            end
            default: mul_a = '0;
        endcase
        mul_b = (r_state == ST_MULI) ? {1'b0, edge_eff} : mul_a;

        // divider requests
        div_req.start    = 1'b0;
        div_req.short_op = 1'b1;
        div_req.dividend = '0;
        div_req.divisor  = {1'b0, edge_eff};
        unique case (r_state)
            ST_DIVN: begin
                div_req.start    = !r_sub;
                div_req.short_op = 1'b0;
                unique case (r_idx)
                    2'd0:    div_req.dividend = {2'b00, r_mag[0], 30'd0};
                    2'd1:    div_req.dividend = {2'b00, r_mag[1], 30'd0};
                    default: div_req.dividend = {2'b00, r_mag[2], 30'd0};
                endcase
                div_req.divisor = r_len;
            end
            ST_DIVS: begin
                div_req.start    = !r_sub;
                div_req.dividend = {32'd0, r_reach, 1'b0};
            end
            ST_DIVO: begin
                div_req.start = !r_sub;
                unique case (r_idx)
                    2'd0:    div_req.dividend = {32'd0, f_mag32(r_org[0])};
                    2'd1:    div_req.dividend = {32'd0, f_mag32(r_org[1])};
                    default: div_req.dividend = {32'd0, f_mag32(r_org[2])};
                endcase
            end
            default: div_req.start = 1'b0;
        endcase

        sqrt_start = (r_state == ST_SQRT) && !r_sub && !short_dir;

        // march issue
        step_a         = (r_state == ST_MARCH) && r_sub && (r_k < r_m) && !hit_now;
        lane_ctl.load  = (r_state == ST_MARCH) && !r_sub;
        lane_ctl.adv_a = step_a;
        lane_ctl.adv_b = r_va;

        // origin tile from |org| / edge, floored toward minus infinity
        unique case (r_idx)
            2'd0:    org_q = 32'(r_org[0][31]);
            2'd1:    org_q = 32'(r_org[1][31]);
            default: org_q = 32'(r_org[2][31]);
        endcase
        rem_lo   = div_rem[30:0];
        t0_val   = T_W'(div_quot[31:0]);
        rem0_val = rem_lo;
        if (org_q[0]) begin
            if (rem_lo == '0) begin
                t0_val = T_W'(0) - T_W'(div_quot[31:0]);
            end else begin
                t0_val   = T_W'(0) - T_W'(div_quot[31:0]) - T_W'(1);
                rem0_val = edge_eff - rem_lo;
            end
        end

        // request completions
        fin_write = accept && (func == FN_WRITE);
        fin_read  = (r_state == ST_READ);
        fin_fill  = (r_state == ST_CLEAR) && clr_last && r_clr_report;
        fin_short = (r_state == ST_SQRT) && !r_sub && short_dir;
        fin_march = (r_state == ST_MARCH) && r_sub &&
                    ((r_m == '0) || hit_now || (r_vc && r_lc));
        fin_any   = fin_write || fin_read || fin_fill || fin_short || fin_march;
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_size_x     <= SIZE_RESET;
            r_size_y     <= SIZE_RESET;
            r_size_z     <= SIZE_RESET;
            r_edge       <= EDGE_RESET;
            r_mask       <= MASK_RESET;
            r_clr_addr   <= '0;
            r_fill_code  <= '0;
            r_clr_report <= 1'b0;
            r_idx        <= '0;
            r_sub        <= 1'b0;
            r_k          <= '0;
            r_va         <= 1'b0;
            r_vb         <= 1'b0;
            r_vc         <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= fin_any;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SIZE_X: r_size_x <= i_cfg_data[5:0];
                    CFG_SIZE_Y: r_size_y <= i_cfg_data[5:0];
                    CFG_SIZE_Z: r_size_z <= i_cfg_data[5:0];
                    CFG_EDGE:   r_edge   <= i_cfg_data;
                    CFG_MASK:   r_mask   <= i_cfg_data[8:0];
                    default:    r_mask   <= r_mask;
                endcase
            end

            // fill request starts a sweep
            if (accept && (func == FN_FILL)) begin
                r_clr_addr   <= '0;
                r_fill_code  <= i_tile_code;
                r_clr_report <= 1'b1;
            end else if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            // per-state step counters
            if (n_state != r_state) begin
                r_idx <= '0;
                r_sub <= 1'b0;
            end else begin
                priority case (r_state)
                    ST_SQ, ST_MULI: r_idx <= r_idx + 2'd1;
                    ST_SQRT: begin
                        if (sqrt_start) r_sub <= 1'b1;
                    end
                    ST_DIVN, ST_DIVS, ST_DIVO: begin
                        if (div_req.start) begin
                            r_sub <= 1'b1;
                        end else if (div_done) begin
                            r_sub <= 1'b0;
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                    ST_MARCH: r_sub <= 1'b1;
                    default: r_sub <= r_sub;
                endcase
            end

            // march pipeline valids
            if (lane_ctl.load) begin
                r_k  <= '0;
                r_va <= 1'b0;
                r_vb <= 1'b0;
                r_vc <= 1'b0;
            end else begin
                if (step_a) r_k <= r_k + SW'(1);
                r_va <= step_a;
                r_vb <= r_va;
                r_vc <= r_vb;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (accept) begin
            r_org[0] <= i_origin_x;
            r_org[1] <= i_origin_y;
            r_org[2] <= i_origin_z;
            r_mag[0] <= f_mag32(i_dir_x);
            r_mag[1] <= f_mag32(i_dir_y);
            r_mag[2] <= f_mag32(i_dir_z);
            r_neg[0] <= i_dir_x[31];
            r_neg[1] <= i_dir_y[31];
            r_neg[2] <= i_dir_z[31];
            r_reach  <= i_reach;
            r_sum    <= '0;
            r_inb_rd <= cell_inb;
        end

        // sum of squares
        if ((r_state == ST_SQ) && (r_idx != 2'd0)) begin
            r_sum <= r_sum + r_prod;
        end
        if (sqrt_done) begin
            r_len <= sqrt_root;
        end
        // unit direction magnitudes, Q1.30
        if ((r_state == ST_DIVN) && div_done) begin
            r_nmag[r_idx] <= div_quot[30:0];
        end
        // per-step distance increments
        if ((r_state == ST_MULI) && (r_idx != 2'd0)) begin
            r_inc[r_idx - 2'd1] <= r_prod[61:0];
        end
        // step count, saturated
        if ((r_state == ST_DIVS) && div_done) begin
            r_m <= (div_quot >= steps_max) ? SW'(MAX_STEPS) : div_quot[SW-1:0];
        end
        // origin tiles
        if ((r_state == ST_DIVO) && div_done) begin
            r_t0[r_idx]   <= t0_val;
            r_rem0[r_idx] <= rem0_val;
        end

        // march pipeline payload
        r_la    <= (r_k == (r_m - SW'(1)));
        r_lb    <= r_la;
        r_lc    <= r_lb;
        r_inb_c <= march_inb;
        r_pc[0] <= lane_p[0];
        r_pc[1] <= lane_p[1];
        r_pc[2] <= lane_p[2];

        // result
        if (fin_any) begin
            r_read_code <= (fin_read && r_inb_rd) ? ram_rdata : 4'd0;
            r_hit       <= fin_march && hit_now;
            r_hit_p[0]  <= (fin_march && hit_now) ? f_sat(r_pc[0]) : 32'd0;
            r_hit_p[1]  <= (fin_march && hit_now) ? f_sat(r_pc[1]) : 32'd0;
            r_hit_p[2]  <= (fin_march && hit_now) ? f_sat(r_pc[2]) : 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // units
    vgrm_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    vgrm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    vgrm_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqrt_start),
        .i_radicand(r_sum),
        .o_done    (sqrt_done),
        .o_root    (sqrt_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        vgrm_lane #(
            .STEP_W(SW)
        ) u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_inc (r_inc[g]),
            .i_neg (r_neg[g]),
            .i_org (r_org[g]),
            .i_t0  (r_t0[g]),
            .i_rem0(r_rem0[g]),
            .i_edge(edge_eff),
            .o_p   (lane_p[g]),
            .o_t   (lane_t[g])
        );
    end

    // ------------------------------------------------------------------
    // outputs
    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_read_code = r_read_code;
    assign o_hit       = r_hit;
    assign o_hit_x     = r_hit_p[0];
    assign o_hit_y     = r_hit_p[1];
    assign o_hit_z     = r_hit_p[2];
endmodule

>>> sim/tb_voxel_grid_ray_march.sv
// tb_voxel_grid_ray_march: self-checking testbench of the voxel grid ray marcher.
// Holds a scoreboard class with its own tile store and fixed-point march predictor.
// Depends on vgrm_pkg and voxel_grid_ray_march.
`timescale 1ns / 100ps

module tb_voxel_grid_ray_march;
    import vgrm_pkg::*;

    localparam int DIM        = 32;
    localparam int STEP_LIMIT = 1024;
    localparam int N_RANDOM   = 570;
    localparam int MAX_FILLS  = 6;
    localparam longint CYCLE_LIMIT = 4000000;

    // one request and one result
    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] cx, cy, cz;
        logic [3:0]         code;
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] dx, dy, dz;
        logic [30:0]        reach;
    } t_grid_req;

    typedef struct {
        logic [3:0]         code;
        logic               hit;
        logic signed [31:0] hx, hy, hz;
    } t_grid_rsp;

    // scoreboard: predicts each result and checks the DUT against it
    class tile_scoreboard;
        bit [3:0]  tiles [DIM*DIM*DIM];
        bit [5:0]  gsize [3];
        bit [30:0] edge_len;
        bit [8:0]  mask;
        t_grid_rsp expected_q [$];
        int        errors, n_checked, n_rays, n_hits;

        function new();
            foreach (tiles[i]) tiles[i] = 4'd0;
            foreach (gsize[i]) gsize[i] = SIZE_RESET;
            edge_len = EDGE_RESET;
            mask     = MASK_RESET;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE_X: gsize[0] = data[5:0];
                CFG_SIZE_Y: gsize[1] = data[5:0];
                CFG_SIZE_Z: gsize[2] = data[5:0];
                CFG_EDGE:   edge_len = data[30:0];
                CFG_MASK:   mask     = data[8:0];
                default: ;
            endcase
        endfunction

        function longint used_dim(int a);
            return (gsize[a] > DIM) ? DIM : longint'(gsize[a]);
        endfunction

        function bit cell_in_grid(longint x, longint y, longint z);
            return x >= 0 && x < used_dim(0) && y >= 0 && y < used_dim(1) &&
                   z >= 0 && z < used_dim(2);
        endfunction

        function int cell_addr(longint x, longint y, longint z);
            return int'((z * DIM + y) * DIM + x);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint floor_tile(longint p, longint e);
            if (p >= 0) return p / e;
            return -((-p + e - 1) / e);
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // fixed-step march; fills r when a solid sample is found
        function void march(t_grid_req q, ref t_grid_rsp r);
            longint org [3], dir [3], unit [3], p [3], t [3];
            longint unsigned sq, len, steps, span, m, off;
            longint e;
            longint code;
            sq = 0;
            e = (edge_len == 0) ? 1 : longint'(edge_len);
            org[0] = q.ox; org[1] = q.oy; org[2] = q.oz;
            dir[0] = q.dx; dir[1] = q.dy; dir[2] = q.dz;
            for (int i = 0; i < 3; i++) begin
                m = (dir[i] < 0) ? longint'(-dir[i]) : longint'(dir[i]);
                sq += m * m;
            end
            if (sq < MIN_LEN_SQ) return;
            len = int_sqrt(sq);
            for (int i = 0; i < 3; i++) begin
                m = (dir[i] < 0) ? longint'(-dir[i]) : longint'(dir[i]);
                unit[i] = longint'((m << 30) / len);
                if (dir[i] < 0) unit[i] = -unit[i];
            end
            steps = (2 * longint'(q.reach)) / e;
            if (steps > STEP_LIMIT) steps = STEP_LIMIT;
            for (longint unsigned k = 0; k < steps; k++) begin
                span = k * e;
                for (int i = 0; i < 3; i++) begin
                    m   = (unit[i] < 0) ? longint'(-unit[i]) : longint'(unit[i]);
                    off = (m * span) >> 31;
                    p[i] = (unit[i] < 0) ? org[i] - longint'(off) : org[i] + longint'(off);
                    t[i] = floor_tile(p[i], e);
                end
                if (cell_in_grid(t[0], t[1], t[2])) begin
                    code = tiles[cell_addr(t[0], t[1], t[2])];
                    if (code < 9 && mask[code]) begin
                        r.hit = 1'b1;
                        r.hx = clip32(p[0]);
                        r.hy = clip32(p[1]);
                        r.hz = clip32(p[2]);
                        return;
                    end
                end
            end
        endfunction

        // accepted request: update the store and queue the expected result
        function void note_request(t_grid_req q);
            t_grid_rsp r;
            r = '{code: 4'd0, hit: 1'b0, hx: 32'sd0, hy: 32'sd0, hz: 32'sd0};
            case (q.func)
                FN_WRITE:
                    if (cell_in_grid(q.cx, q.cy, q.cz))
                        tiles[cell_addr(q.cx, q.cy, q.cz)] = q.code;
                FN_READ:
                    if (cell_in_grid(q.cx, q.cy, q.cz))
                        r.code = tiles[cell_addr(q.cx, q.cy, q.cz)];
                FN_FILL:
                    foreach (tiles[i]) tiles[i] = q.code;
                default: begin
                    n_rays++;
                    march(q, r);
                    if (r.hit) n_hits++;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_grid_rsp a);
            t_grid_rsp x;
            n_checked++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request pending (code %0d hit %0d)",
                         $time, a.code, a.hit);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            if (a.code !== x.code) begin
                $display("%0t: read_code expected %0d actual %0d", $time, x.code, a.code);
                errors++;
            end
            if (a.hit !== x.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, x.hit, a.hit);
                errors++;
            end
            if (a.hx !== x.hx || a.hy !== x.hy || a.hz !== x.hz) begin
                $display("%0t: hit pos expected %h %h %h actual %h %h %h", $time,
                         x.hx, x.hy, x.hz, a.hx, a.hy, a.hz);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk, i_rst_n, start, busy;
    logic [1:0]            i_func;
    logic signed [15:0]    i_cell_x, i_cell_y, i_cell_z;
    logic [3:0]            i_tile_code;
    logic signed [31:0]    i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0]    i_dir_x, i_dir_y, i_dir_z;
    logic [30:0]           i_reach;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid, o_hit;
    logic [3:0]            o_read_code;
    logic signed [31:0]    o_hit_x, o_hit_y, o_hit_z;

    tile_scoreboard sb = new();
    longint cycles = 0;
    int     n_fills = 0;

    voxel_grid_ray_march i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y), .i_cell_z(i_cell_z),
        .i_tile_code(i_tile_code), .i_origin_x(i_origin_x), .i_origin_y(i_origin_y),
        .i_origin_z(i_origin_z), .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_reach(i_reach), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_read_code(o_read_code),
        .o_hit(o_hit), .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_hit_z(o_hit_z)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, sb.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{code: o_read_code, hit: o_hit, hx: o_hit_x, hy: o_hit_y,
                              hz: o_hit_z});
    end

    // drive one request and hold it until taken
    task automatic send_req(t_grid_req q);
        @(negedge i_clk);
        i_func = q.func;
        i_cell_x = q.cx; i_cell_y = q.cy; i_cell_z = q.cz;
        i_tile_code = q.code;
        i_origin_x = q.ox; i_origin_y = q.oy; i_origin_z = q.oz;
        i_dir_x = q.dx; i_dir_y = q.dy; i_dir_z = q.dz;
        i_reach = q.reach;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(q);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // wait for every pending result, then a margin for the block to settle
    task automatic drain();
        idle_cycles(1);
        while (sb.outstanding() > 0 || busy) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_grid(int sx, int sy, int sz, logic [30:0] e, logic [8:0] m);
        drain();
        write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(CFG_EDGE, CFG_DATA_W'(e));
        write_reg(CFG_MASK, CFG_DATA_W'(m));
    endtask

    function automatic t_grid_req cell_req(t_func f, int x, int y, int z, int c);
        t_grid_req q;
        q = '{func: f, cx: 16'(x), cy: 16'(y), cz: 16'(z), code: 4'(c),
              ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0, reach: 0};
        return q;
    endfunction

    function automatic t_grid_req ray_req(logic signed [31:0] ox, oy, oz, dx, dy, dz,
                                          logic [30:0] r);
        t_grid_req q;
        q = cell_req(FN_RAY, 0, 0, 0, 0);
        q.ox = ox; q.oy = oy; q.oz = oz;
        q.dx = dx; q.dy = dy; q.dz = dz;
        q.reach = r;
        return q;
    endfunction

    // random request shaped by the current grid setting
    function automatic t_grid_req rand_req();
        t_grid_req q;
        int sel;
        longint e, ext [3], maxext;
        logic signed [31:0] o [3], d [3];
        sel = $urandom_range(0, 99);
        e = (sb.edge_len == 0) ? 1 : longint'(sb.edge_len);
        maxext = 1;
        for (int i = 0; i < 3; i++) begin
            ext[i] = sb.used_dim(i) * e;
            if (ext[i] < 1) ext[i] = 1;
            if (ext[i] > 64'd2147483647) ext[i] = 64'd2147483647;
            if (ext[i] > maxext) maxext = ext[i];
        end
        if (sel < 55 || (sel < 56 && n_fills >= MAX_FILLS)) begin
            q = cell_req(sel < 30 ? FN_WRITE : FN_READ, 0, 0, 0, 0);
            if ($urandom_range(0, 99) < 15) begin
                q.cx = 16'($urandom); q.cy = 16'($urandom); q.cz = 16'($urandom);
            end else begin
                q.cx = 16'($urandom_range(0, sb.used_dim(0)) - $urandom_range(0, 1));
                q.cy = 16'($urandom_range(0, sb.used_dim(1)) - $urandom_range(0, 1));
                q.cz = 16'($urandom_range(0, sb.used_dim(2)) - $urandom_range(0, 1));
            end
            q.code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
        end else if (sel < 56) begin
            n_fills++;
            q = cell_req(FN_FILL, 0, 0, 0, $urandom_range(0, 15));
        end else if (sel < 64) begin
            // noise: every field at random
            q = ray_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        31'($urandom));
        end else begin
            for (int i = 0; i < 3; i++) begin
                o[i] = 32'({$urandom, $urandom} % ext[i]);
                if ($urandom_range(0, 9) == 0) d[i] = $urandom_range(0, 8) - 4;
                else d[i] = $signed($urandom) >>> $urandom_range(0, 20);
            end
            q = ray_req(o[0], o[1], o[2], d[0], d[1], d[2],
                        31'(({$urandom, $urandom} % (2 * maxext + 1)) & 64'h7FFFFFFF));
        end
        return q;
    endfunction

    // random traffic in bursts with gaps of random length
    task automatic random_phase(int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && left > 0; b++) begin
                send_req(rand_req());
                left--;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] HALF = 32'sh0000_8000;

    initial begin
        i_rst_n = 1'b0; start = 1'b0;
        i_func = FN_WRITE; i_cell_x = 0; i_cell_y = 0; i_cell_z = 0; i_tile_code = 0;
        i_origin_x = 0; i_origin_y = 0; i_origin_z = 0;
        i_dir_x = 0; i_dir_y = 0; i_dir_z = 0; i_reach = 0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_SIZE_X; i_cfg_data = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: corners, bounds, codes, ray edge cases at reset setting
        send_req(cell_req(FN_WRITE, 0, 0, 0, 2));
        send_req(cell_req(FN_WRITE, 31, 31, 31, 3));
        send_req(cell_req(FN_WRITE, 32, 0, 0, 2));
        send_req(cell_req(FN_WRITE, -1, -32768, 32767, 4));
        send_req(cell_req(FN_WRITE, 5, 5, 5, 15));
        send_req(cell_req(FN_WRITE, 10, 4, 4, 4));
        send_req(cell_req(FN_READ, 0, 0, 0, 0));
        send_req(cell_req(FN_READ, 31, 31, 31, 0));
        send_req(cell_req(FN_READ, 32, 0, 0, 0));
        send_req(cell_req(FN_READ, -32768, 32767, 0, 0));
        send_req(cell_req(FN_READ, 5, 5, 5, 0));
        send_req(ray_req(HALF, 4 * ONE + HALF, 4 * ONE + HALF, ONE, 0, 0, 20 * ONE));
        send_req(ray_req(20 * ONE + HALF, 4 * ONE + HALF, 4 * ONE + HALF, -3 * ONE, 0, 0,
                         20 * ONE));
        // short direction just under and just over the length threshold
        send_req(ray_req(HALF, 4 * ONE + HALF, 4 * ONE + HALF, 6, 0, 0, 20 * ONE));
        send_req(ray_req(HALF, 4 * ONE + HALF, 4 * ONE + HALF, 7, 0, 0, 20 * ONE));
        // step count saturates
        send_req(ray_req(-100 * ONE, 50 * ONE, 3, ONE, ONE, -ONE, 31'h7FFF_FFFF));
        send_req(ray_req(HALF, HALF, HALF, ONE, ONE, ONE, ONE));
        send_req(ray_req(31 * ONE, 31 * ONE, 31 * ONE, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 100 * ONE));
        send_req(cell_req(FN_FILL, 0, 0, 0, 9));
        send_req(cell_req(FN_READ, 3, 3, 3, 0));
        send_req(ray_req(HALF, HALF, HALF, ONE, 2 * ONE, 3 * ONE, 10 * ONE));
        send_req(cell_req(FN_FILL, 0, 0, 0, 0));
        n_fills = 2;
        random_phase(N_RANDOM / 6);

        set_grid(8, 8, 8, 31'h0000_8000, 9'h1FF);
        random_phase(N_RANDOM / 6);

        set_grid(1, 1, 1, 31'd1, 9'h000);
        random_phase(N_RANDOM / 12);
        set_grid(1, 1, 1, 31'd1, 9'h1FF);
        random_phase(N_RANDOM / 12);

        // zero and oversized sizes, zero edge
        set_grid(63, 0, 5, 31'd0, 9'h1FE);
        random_phase(N_RANDOM / 12);
        set_grid(63, 32, 40, 31'd0, 9'h1FE);
        random_phase(N_RANDOM / 12);

        // widest edge: hit past the 32-bit range saturates
        set_grid(2, 1, 1, 31'h7FFF_FFFF, 9'h004);
        send_req(cell_req(FN_WRITE, 1, 0, 0, 2));
        send_req(ray_req(32'sh4000_0100, 0, 0, ONE, 0, 0, 31'h7FFF_FFFF));
        send_req(ray_req(32'sh7FFF_FFFF, 0, 0, ONE, 0, 0, 31'h7FFF_FFFF));
        random_phase(N_RANDOM / 12);

        set_grid(32, 32, 32, 31'h0003_0000, 9'h155);
        random_phase(N_RANDOM / 6);

        drain();
        repeat (1500) @(posedge i_clk);
        $display("Checked %0d results: %0d raycasts (%0d hits), %0d fills.",
                 sb.n_checked, sb.n_rays, sb.n_hits, n_fills);
        $display("Grid settings covered zero, clamped and full sizes, edges 0 to max.");
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.outstanding());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
